[hdl/gpf_pkg.sv]
// gpf_pkg: shared types and constants for the goldbach prime pair finder
// used by the controller, datapath, top level and checker; no dependencies
package gpf_pkg;

	localparam int VALUE_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_PAIR   = 7'b0000100,
		S_DIVCHK = 7'b0001000,
		S_MOD    = 7'b0010000,
		S_REM    = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic    load;
		logic    init_pair;
		logic    next_pair;
		logic    load_cand;
		logic    sel_hi;
		logic    start_mod;
		logic    mod_step;
		logic    next_div;
		logic    emit;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic past_half;
		logic sq_over;
		logic mod_last;
		logic rem_zero;
	} dp_stat_t;

endpackage

[hdl/gpf_datapath.sv]
// gpf_datapath: pair counters, trial divisor with running square, bit-serial remainder
// unit and result register; depends on gpf_pkg
module gpf_datapath import gpf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic [VALUE_WIDTH-1:0] even_value,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	output status_t                status,
	output logic [VALUE_WIDTH-1:0] small_prime,
	output logic [VALUE_WIDTH-1:0] large_prime
);

	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  g_q, lo_q, hi_q, cand_q, d_q, r_q, sh_q;
	logic [W:0]    sq_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic          ge;

	assign trial = {r_q, sh_q[W-1]};
	assign ge    = trial >= {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g_q <= even_value;
		end
		if (cmd.init_pair) begin
			lo_q <= W'(2);
			hi_q <= g_q - W'(2);
		end else if (cmd.next_pair) begin
			lo_q <= lo_q + W'(1);
			hi_q <= hi_q - W'(1);
		end
		if (cmd.load_cand) begin
			cand_q <= cmd.sel_hi ? hi_q : lo_q;
			d_q    <= W'(2);
			sq_q   <= (W + 1)'(4);
		end else if (cmd.next_div) begin
			d_q  <= d_q + W'(1);
			sq_q <= sq_q + {d_q, 1'b1};
		end
		if (cmd.start_mod) begin
			r_q   <= '0;
			sh_q  <= cand_q;
			cnt_q <= CW'(W);
		end else if (cmd.mod_step) begin
			r_q   <= ge ? W'(trial - {1'b0, d_q}) : W'(trial);
			sh_q  <= {sh_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.emit) begin
			status      <= cmd.code;
			small_prime <= (cmd.code == ST_FOUND) ? lo_q : '0;
			large_prime <= (cmd.code == ST_FOUND) ? hi_q : '0;
		end
	end

	assign stat.invalid   = (g_q <= W'(2)) || g_q[0];
	assign stat.past_half = lo_q > (g_q >> 1);
	assign stat.sq_over   = sq_q > {1'b0, cand_q};
	assign stat.mod_last  = cnt_q == CW'(1);
	assign stat.rem_zero  = r_q == '0;

endmodule

[hdl/gpf_controller.sv]
// gpf_controller: one-hot sequencer for the pair search and the result handshake
// depends on gpf_pkg
module gpf_controller import gpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t  state_q, state_d;
	status_t res_q, res_d;
	logic    phase_hi_q, phase_hi_d;
	logic    out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.code   = res_q;
		state_d    = state_q;
		res_d      = res_q;
		phase_hi_d = phase_hi_q;
		in_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.invalid) begin
					res_d   = ST_INVALID;
					state_d = S_DONE;
				end else begin
					cmd.init_pair = 1'b1;
					state_d       = S_PAIR;
				end
			end
			S_PAIR: begin
				if (stat.past_half) begin
					res_d   = ST_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.load_cand = 1'b1;
					phase_hi_d    = 1'b0;
					state_d       = S_DIVCHK;
				end
			end
			S_DIVCHK: begin
				if (stat.sq_over) begin
					if (!phase_hi_q) begin
						cmd.load_cand = 1'b1;
						cmd.sel_hi    = 1'b1;
						phase_hi_d    = 1'b1;
					end else begin
						res_d   = ST_FOUND;
						state_d = S_DONE;
					end
				end else begin
					cmd.start_mod = 1'b1;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = S_REM;
				end
			end
			S_REM: begin
				if (stat.rem_zero) begin
					cmd.next_pair = 1'b1;
					state_d       = S_PAIR;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = S_DIVCHK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_INVALID;
			phase_hi_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_q      <= res_d;
			phase_hi_q <= phase_hi_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/goldbach_prime_pair_finder_unit.sv]
// search: data dependent in length; each trial divisor takes a pass of the
// bit-serial remainder unit, and divisors are tried up to the square root of each candidate
// throughput: one word at a time; a new word is taken while the previous result waits
// reset: arst_n clears the sequencer and the output valid flag; no result pending after it
// top level: stream wrapper around gpf_controller and gpf_datapath; depends on gpf_pkg
module goldbach_prime_pair_finder_unit import gpf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// even_value
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// status, small_prime, large_prime
	output logic [((2*VALUE_WIDTH+2+7)/8)*8-1:0]       m_axis_tdata
);

	localparam int OUT_W = ((2 * VALUE_WIDTH + 2 + 7) / 8) * 8;

	dp_cmd_t                cmd;
	dp_stat_t               stat;
	status_t                status;
	logic [VALUE_WIDTH-1:0] small_prime, large_prime;

	gpf_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	gpf_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.even_value  (s_axis_tdata[VALUE_WIDTH-1:0]),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.small_prime (small_prime),
		.large_prime (large_prime)
	);

	assign m_axis_tdata = OUT_W'({large_prime, small_prime, status});

endmodule

[hdl/gpf_checker.sv]
// gpf_checker: port-level assertions for goldbach_prime_pair_finder_unit, bound to it
// depends on gpf_pkg
module gpf_checker import gpf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_axis_tvalid,
	input logic                                 s_axis_tready,
	input logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [((2*VALUE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);

	localparam int W = VALUE_WIDTH;

	logic [1:0]   st;
	logic [W-1:0] sp, lp;

	assign st = m_axis_tdata[1:0];
	assign sp = m_axis_tdata[W+1:2];
	assign lp = m_axis_tdata[2*W+1:W+2];

	// result word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word taken while search busy");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (st == ST_FOUND || st == ST_INVALID || st == ST_NOT_FOUND))
		else $error("unknown status code");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st != ST_FOUND |-> sp == '0 && lp == '0)
		else $error("primes nonzero without a split");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == ST_FOUND |-> sp <= lp && sp >= W'(2) && !lp[0] == (lp == W'(2)))
		else $error("split primes out of order");

endmodule

bind goldbach_prime_pair_finder_unit gpf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_gpf_checker (.*);
